### hdl/pcbs_pkg.sv
// Shared constants, types and helpers for the per-class box suppression unit.
package pcbs_pkg;

    localparam int MAX_DET_DEFAULT = 64;
    localparam int COORD_W         = 16;
    localparam int CONF_W          = 16;
    localparam int CLASS_W         = 8;
    localparam int BOX_W           = 4 * COORD_W;
    localparam int SC_W            = CONF_W + CLASS_W;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CONF_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NMS_THRESHOLD  = 1'd1;

    localparam logic [CFG_DATA_W-1:0] CONF_THRESHOLD_RST = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] NMS_THRESHOLD_RST  = 16'd29491;

    typedef struct packed {
        logic done;
        logic hit;
    } t_iou_res;

    function automatic logic [COORD_W-1:0] f_extent(
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W-1:0] hi
    );
        f_extent = (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

### hdl/pcbs_det_if.sv
// Detection input channel.
interface pcbs_det_if;
    logic        valid;
    logic        ready;
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic [15:0] confidence;
    logic [7:0]  class_index;
    logic        final_item;

    modport source (
        output valid, box_x1, box_y1, box_x2, box_y2, confidence, class_index, final_item,
        input  ready
    );
    modport sink (
        input  valid, box_x1, box_y1, box_x2, box_y2, confidence, class_index, final_item,
        output ready
    );
endinterface

### hdl/pcbs_res_if.sv
// Surviving box result channel.
interface pcbs_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] kept_x1;
    logic [15:0] kept_y1;
    logic [15:0] kept_x2;
    logic [15:0] kept_y2;
    logic [15:0] kept_confidence;
    logic [7:0]  kept_class;
    logic        last_result;
    logic        none_kept;
    logic        store_overflowed;

    modport source (
        output valid, kept_x1, kept_y1, kept_x2, kept_y2, kept_confidence, kept_class,
               last_result, none_kept, store_overflowed,
        input  ready
    );
    modport sink (
        input  valid, kept_x1, kept_y1, kept_x2, kept_y2, kept_confidence, kept_class,
               last_result, none_kept, store_overflowed,
        output ready
    );
endinterface

### hdl/per_class_box_suppression_unit.sv
// Per-class greedy non-maximum suppression top level.
// Detections are taken one per cycle while the unit is idle; those above the confidence
// threshold are stored, up to MAX_DETECTIONS, and extra ones set the overflow flag. On the
// final item the unit stops taking input and works the frame out of its store: each pick
// is a scan of all N stored entries for the best remaining box, followed by a scan that
// runs the shared overlap unit on each live box of the same class.
module per_class_box_suppression_unit #(
    parameter int MAX_DETECTIONS = pcbs_pkg::MAX_DET_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pcbs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [pcbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pcbs_det_if.sink                          i_det,
    pcbs_res_if.source                        o_res
);
    import pcbs_pkg::*;

    localparam int AW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int CW = $clog2(MAX_DETECTIONS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DETECTIONS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SRCH_RD  = 4'd1;
    localparam logic [3:0] ST_SRCH_CMP = 4'd2;
    localparam logic [3:0] ST_SRCH_END = 4'd3;
    localparam logic [3:0] ST_EMIT     = 4'd4;
    localparam logic [3:0] ST_TAKE     = 4'd5;
    localparam logic [3:0] ST_SUP_RD   = 4'd6;
    localparam logic [3:0] ST_SUP_CHK  = 4'd7;
    localparam logic [3:0] ST_SUP_WAIT = 4'd8;

    logic [3:0]              r_state;
    logic [15:0]             r_conf_thr, r_nms_thr;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_ovf;
    logic [MAX_DETECTIONS-1:0] r_alive;
    logic [CW-1:0]           r_idx;
    logic                    r_found;
    logic [AW-1:0]           r_best_idx;
    logic [BOX_W-1:0]        r_best_box, r_pend_box;
    logic [SC_W-1:0]         r_best_sc, r_pend_sc;
    logic                    r_pend_valid;
    logic                    r_emit_last;
    logic                    r_out_valid;
    logic [BOX_W-1:0]        r_out_box;
    logic [SC_W-1:0]         r_out_sc;
    logic                    r_out_last, r_out_none, r_out_ovf;

    logic                    det_xfer, qualifies, wr_en, rd_en, iou_start;
    logic [BOX_W-1:0]        rd_box;
    logic [SC_W-1:0]         rd_sc;
    logic [39:0]             cand_key, best_key;
    t_iou_res                iou_res;

    assign det_xfer  = i_det.valid && i_det.ready;
    assign qualifies = i_det.confidence > r_conf_thr;
    assign wr_en     = det_xfer && qualifies && (r_count < MAX_CNT);
    assign n_count   = wr_en ? r_count + CW'(1) : r_count;
    assign rd_en     = ((r_state == ST_SRCH_RD) || (r_state == ST_SUP_RD))
                       && (r_idx != r_count) && r_alive[r_idx[AW-1:0]];
    assign iou_start = (r_state == ST_SUP_CHK)
                       && (rd_sc[SC_W-1:CONF_W] == r_pend_sc[SC_W-1:CONF_W]);
    assign cand_key  = {rd_sc[SC_W-1:CONF_W], ~rd_sc[CONF_W-1:0], rd_box[COORD_W-1:0]};
    assign best_key  = {r_best_sc[SC_W-1:CONF_W], ~r_best_sc[CONF_W-1:0],
                        r_best_box[COORD_W-1:0]};

    pcbs_store #(
        .MAX_DETECTIONS(MAX_DETECTIONS),
        .AW            (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_box ({i_det.box_y2, i_det.box_x2, i_det.box_y1, i_det.box_x1}),
        .i_wr_sc  ({i_det.class_index, i_det.confidence}),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_box (rd_box),
        .o_rd_sc  (rd_sc)
    );

    pcbs_iou_unit u_iou (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (iou_start),
        .i_box_a        (r_pend_box),
        .i_box_b        (rd_box),
        .i_nms_threshold(r_nms_thr),
        .o_res          (iou_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_thr <= CONF_THRESHOLD_RST;
            r_nms_thr  <= NMS_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CONF_THRESHOLD: r_conf_thr <= i_cfg_data;
                CFG_NMS_THRESHOLD:  r_nms_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_alive      <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_emit_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (det_xfer) begin
                        r_count <= n_count;
                        if (qualifies && (r_count == MAX_CNT)) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_det.final_item) begin
                            for (int i = 0; i < MAX_DETECTIONS; i++) begin
                                r_alive[i] <= (CW'(i) < n_count);
                            end
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= ST_SRCH_RD;
                        end
                    end
                end
                ST_SRCH_RD: begin
                    if (r_idx == r_count) begin
                        r_state <= ST_SRCH_END;
                    end else if (r_alive[r_idx[AW-1:0]]) begin
                        r_state <= ST_SRCH_CMP;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_SRCH_CMP: begin
                    if (!r_found || (cand_key < best_key)) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_idx[AW-1:0];
                        r_best_box <= rd_box;
                        r_best_sc  <= rd_sc;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= ST_SRCH_RD;
                end
                ST_SRCH_END: begin
                    r_out_ovf <= r_ovf;
                    if (r_found) begin
                        if (r_pend_valid) begin
                            r_out_box   <= r_pend_box;
                            r_out_sc    <= r_pend_sc;
                            r_out_last  <= 1'b0;
                            r_out_none  <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_emit_last <= 1'b0;
                            r_state     <= ST_EMIT;
                        end else begin
                            r_state <= ST_TAKE;
                        end
                    end else begin
                        r_out_box   <= r_pend_valid ? r_pend_box : '0;
                        r_out_sc    <= r_pend_valid ? r_pend_sc : '0;
                        r_out_none  <= !r_pend_valid;
                        r_out_last  <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_emit_last <= 1'b1;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_emit_last) begin
                            r_count      <= '0;
                            r_ovf        <= 1'b0;
                            r_pend_valid <= 1'b0;
                            r_state      <= ST_IDLE;
                        end else begin
                            r_state <= ST_TAKE;
                        end
                    end
                end
                ST_TAKE: begin
                    r_pend_box          <= r_best_box;
                    r_pend_sc           <= r_best_sc;
                    r_pend_valid        <= 1'b1;
                    r_alive[r_best_idx] <= 1'b0;
                    r_idx               <= '0;
                    r_state             <= ST_SUP_RD;
                end
                ST_SUP_RD: begin
                    if (r_idx == r_count) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= ST_SRCH_RD;
                    end else if (r_alive[r_idx[AW-1:0]]) begin
                        r_state <= ST_SUP_CHK;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_SUP_CHK: begin
                    if (iou_start) begin
                        r_state <= ST_SUP_WAIT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_SUP_RD;
                    end
                end
                ST_SUP_WAIT: begin
                    if (iou_res.done) begin
                        if (iou_res.hit) begin
                            r_alive[r_idx[AW-1:0]] <= 1'b0;
                        end
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_SUP_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_det.ready            = (r_state == ST_IDLE);
    assign o_res.valid            = r_out_valid;
    assign o_res.kept_x1          = r_out_box[15:0];
    assign o_res.kept_y1          = r_out_box[31:16];
    assign o_res.kept_x2          = r_out_box[47:32];
    assign o_res.kept_y2          = r_out_box[63:48];
    assign o_res.kept_confidence  = r_out_sc[CONF_W-1:0];
    assign o_res.kept_class       = r_out_sc[SC_W-1:CONF_W];
    assign o_res.last_result      = r_out_last;
    assign o_res.none_kept        = r_out_none;
    assign o_res.store_overflowed = r_out_ovf;
endmodule

### hdl/pcbs_store.sv
// Detection store: box and score/class memories with one write and one registered read port.
module pcbs_store #(
    parameter int MAX_DETECTIONS = pcbs_pkg::MAX_DET_DEFAULT,
    parameter int AW             = $clog2(MAX_DETECTIONS)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [pcbs_pkg::BOX_W-1:0] i_wr_box,
    input  logic [pcbs_pkg::SC_W-1:0]  i_wr_sc,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [pcbs_pkg::BOX_W-1:0] o_rd_box,
    output logic [pcbs_pkg::SC_W-1:0]  o_rd_sc
);
    import pcbs_pkg::*;

    logic [BOX_W-1:0] r_box_mem [MAX_DETECTIONS];
    logic [SC_W-1:0]  r_sc_mem  [MAX_DETECTIONS];
    logic [BOX_W-1:0] r_rd_box;
    logic [SC_W-1:0]  r_rd_sc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_box_mem[i_wr_addr] <= i_wr_box;
            r_sc_mem[i_wr_addr]  <= i_wr_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_box <= r_box_mem[i_rd_addr];
            r_rd_sc  <= r_sc_mem[i_rd_addr];
        end
    end

    assign o_rd_box = r_rd_box;
    assign o_rd_sc  = r_rd_sc;
endmodule

### hdl/pcbs_iou_unit.sv
// Overlap test of two boxes on one shared multiplier; a new test starts only from idle.
module pcbs_iou_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pcbs_pkg::BOX_W-1:0] i_box_a,
    input  logic [pcbs_pkg::BOX_W-1:0] i_box_b,
    input  logic [15:0]                i_nms_threshold,
    output pcbs_pkg::t_iou_res         o_res
);
    import pcbs_pkg::*;

    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_INTER = 3'd1;
    localparam logic [2:0] STEP_AREA_A = 3'd2;
    localparam logic [2:0] STEP_AREA_B = 3'd3;
    localparam logic [2:0] STEP_UNION = 3'd4;
    localparam logic [2:0] STEP_P_LO  = 3'd5;
    localparam logic [2:0] STEP_P_HI  = 3'd6;
    localparam logic [2:0] STEP_CMP   = 3'd7;

    logic [2:0]  r_step;
    logic [15:0] r_iex, r_iey, r_aex, r_aey, r_bex, r_bey;
    logic [31:0] r_inter, r_area_a, r_area_b, r_plo;
    logic [33:0] r_uni, r_phi;
    logic [16:0] mul_a, mul_b;
    logic [33:0] product;
    logic [49:0] lhs, rhs;
    logic [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic [15:0] ix1, iy1, ix2, iy2;

    assign {ay2, ax2, ay1, ax1} = i_box_a;
    assign {by2, bx2, by1, bx1} = i_box_b;
    assign ix1 = (ax1 > bx1) ? ax1 : bx1;
    assign iy1 = (ay1 > by1) ? ay1 : by1;
    assign ix2 = (ax2 < bx2) ? ax2 : bx2;
    assign iy2 = (ay2 < by2) ? ay2 : by2;

    always_comb begin
        case (r_step)
            STEP_INTER: begin
                mul_a = {1'b0, r_iex};
                mul_b = {1'b0, r_iey};
            end
            STEP_AREA_A: begin
                mul_a = {1'b0, r_aex};
                mul_b = {1'b0, r_aey};
            end
            STEP_AREA_B: begin
                mul_a = {1'b0, r_bex};
                mul_b = {1'b0, r_bey};
            end
            STEP_P_LO: begin
                mul_a = {1'b0, i_nms_threshold};
                mul_b = {1'b0, r_uni[15:0]};
            end
            STEP_P_HI: begin
                mul_a = {1'b0, i_nms_threshold};
                mul_b = r_uni[32:16];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;
    assign lhs = {2'd0, r_inter, 16'd0};
    assign rhs = {r_phi, 16'd0} + {18'd0, r_plo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            case (r_step)
                STEP_IDLE: begin
                    if (i_start) begin
                        r_step <= STEP_INTER;
                    end
                end
                STEP_CMP: r_step <= STEP_IDLE;
                default:  r_step <= r_step + 3'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            STEP_IDLE: begin
                r_iex <= f_extent(ix1, ix2);
                r_iey <= f_extent(iy1, iy2);
                r_aex <= f_extent(ax1, ax2);
                r_aey <= f_extent(ay1, ay2);
                r_bex <= f_extent(bx1, bx2);
                r_bey <= f_extent(by1, by2);
            end
            STEP_INTER:  r_inter  <= product[31:0];
            STEP_AREA_A: r_area_a <= product[31:0];
            STEP_AREA_B: r_area_b <= product[31:0];
            STEP_UNION:  r_uni <= {2'd0, r_area_a} + {2'd0, r_area_b} - {2'd0, r_inter};
            STEP_P_LO:   r_plo <= product[31:0];
            STEP_P_HI:   r_phi <= product;
            default: ;
        endcase
    end

    assign o_res.done = (r_step == STEP_CMP);
    assign o_res.hit  = (r_step == STEP_CMP) && (lhs > rhs);
endmodule
